// ===== rtl/olst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olst_pkg
// Shared types and constants for the ordered list store: operation and
// status codes, the command broadcast to the storage cells.
// ----------------------------------------------------------------------------
package olst_pkg;

   localparam int unsigned DEFAULT_CAPACITY = 16;
   localparam int unsigned DATA_W = 32;
   localparam int unsigned CNT_W = 6;
   localparam int unsigned KIND_W = 3;
   localparam int unsigned STAT_W = 2;

   typedef enum logic [KIND_W-1:0] {
      KIND_APPEND       = 3'd0,
      KIND_REMOVE_FIRST = 3'd1,
      KIND_REMOVE_LAST  = 3'd2,
      KIND_REMOVE_AT    = 3'd3,
      KIND_LIST_ALL     = 3'd4
   } kind_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK     = 2'd0,
      STAT_EMPTY  = 2'd1,
      STAT_BADPOS = 2'd2,
      STAT_FULL   = 2'd3
   } status_type;

   // command seen by every cell in the same cycle
   typedef struct packed {
      logic                     append;
      logic                     shift;
      logic                     rotate;
      logic [CNT_W-1:0]         count;
      logic [CNT_W-1:0]         start;
      logic signed [DATA_W-1:0] value;
   } cell_cmd_type;

endpackage

// ===== rtl/olst_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olst_cell
// One list slot. Loads an appended value, takes its right neighbor's value
// when the list closes a gap, and rotates toward the head while listing.
// ----------------------------------------------------------------------------
module olst_cell #(
   parameter int unsigned IDX = 0
) (
   input  logic                               clock,
   input  olst_pkg::cell_cmd_type             cmd,
   input  logic signed [olst_pkg::DATA_W-1:0] next_data,
   input  logic signed [olst_pkg::DATA_W-1:0] head_data,
   output logic signed [olst_pkg::DATA_W-1:0] data
);
   import olst_pkg::*;

   localparam logic [CNT_W-1:0] MY_IDX  = CNT_W'(IDX);
   localparam logic [CNT_W-1:0] MY_NEXT = CNT_W'(IDX + 1);

   logic signed [DATA_W-1:0] data_ff;
   logic signed [DATA_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      priority if (cmd.append && (MY_IDX == cmd.count)) begin
         data_in = cmd.value;
      end else if (cmd.shift && (MY_IDX >= cmd.start) && (MY_NEXT < cmd.count)) begin
         data_in = next_data;
      end else if (cmd.rotate && (MY_NEXT < cmd.count)) begin
         data_in = next_data;
      end else if (cmd.rotate && (MY_NEXT == cmd.count)) begin
         // tail slot wraps the head around
         data_in = head_data;
      end else begin
         data_in = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

// ===== rtl/ordered_list_store_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_store_core
// Bounded ordered list of signed 32-bit values kept in a row of cells.
//
//   channel  dir  handshake             payload
//   req_     in   req_valid/req_stall   req_kind, req_value, req_position
//   rsp_     out  rsp_valid/rsp_stall   rsp_status, rsp_element,
//                                       rsp_is_final, rsp_held_count
//
// append and removals: every cell moves at once in the accept cycle and the
// status transaction comes out of the register the cycle after. list all
// holds the block until its closing transaction: the accept cycle sends
// nothing, then, while rsp_ is not stalled, the row rotates one slot a cycle
// past the head, once per held element, so the list is back in place, then a
// closing transaction follows. a stall on rsp_ freezes the rotation. a new
// request is taken while idle and the output register is free or draining.
// reset clears the count; slot contents are not cleared.
// ----------------------------------------------------------------------------
module ordered_list_store_core #(
   parameter int unsigned CAPACITY = olst_pkg::DEFAULT_CAPACITY
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [olst_pkg::KIND_W-1:0]        req_kind,
   input  logic signed [olst_pkg::DATA_W-1:0] req_value,
   input  logic [olst_pkg::CNT_W-1:0]         req_position,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [olst_pkg::STAT_W-1:0]        rsp_status,
   output logic signed [olst_pkg::DATA_W-1:0] rsp_element,
   output logic                               rsp_is_final,
   output logic [olst_pkg::CNT_W-1:0]         rsp_held_count
);
   import olst_pkg::*;

   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
   localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_LIST  = 3'b010,
      S_CLOSE = 3'b100
   } state_type;

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CNT_W-1:0]        step_ff, step_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]       status_ff, status_in;
   logic signed [DATA_W-1:0] element_ff, element_in;
   logic                    final_ff, final_in;
   logic [CNT_W-1:0]        held_ff, held_in;

   logic                    out_free;
   logic                    req_accept;
   cell_cmd_type            cmd;
   logic signed [DATA_W-1:0] cell_data [CAPACITY];

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = !((state_ff == S_IDLE) && out_free);
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      status_in    = status_ff;
      element_in   = element_ff;
      final_in     = final_ff;
      held_in      = held_ff;
      cmd.append   = 1'b0;
      cmd.shift    = 1'b0;
      cmd.rotate   = 1'b0;
      cmd.count    = count_ff;
      cmd.start    = req_position - ONE_CNT;
      cmd.value    = req_value;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               rsp_valid_in = 1'b1;
               status_in    = STAT_OK;
               element_in   = '0;
               final_in     = 1'b1;
               unique case (req_kind)
                  KIND_APPEND: begin
                     if (count_ff >= CAP_CNT) begin
                        status_in = STAT_FULL;
                     end else begin
                        cmd.append = 1'b1;
                        count_in   = count_ff + ONE_CNT;
                     end
                  end
                  KIND_REMOVE_FIRST: begin
                     if (count_ff == '0) begin
                        status_in = STAT_EMPTY;
                     end else begin
                        cmd.shift = 1'b1;
                        cmd.start = '0;
                        count_in  = count_ff - ONE_CNT;
                     end
                  end
                  KIND_REMOVE_LAST: begin
                     if (count_ff == '0) begin
                        status_in = STAT_EMPTY;
                     end else begin
                        count_in = count_ff - ONE_CNT;
                     end
                  end
                  KIND_REMOVE_AT: begin
                     if (count_ff == '0) begin
                        status_in = STAT_EMPTY;
                     end else if ((req_position == '0) || (req_position > count_ff)) begin
                        status_in = STAT_BADPOS;
                     end else begin
                        cmd.shift = 1'b1;
                        count_in  = count_ff - ONE_CNT;
                     end
                  end
                  KIND_LIST_ALL: begin
                     if (count_ff != '0) begin
                        // nothing goes out now; the first element follows
                        rsp_valid_in = 1'b0;
                        step_in      = '0;
                        state_in     = S_LIST;
                     end
                  end
                  default: begin
                  end
               endcase
               held_in = count_in;
            end
         end
         S_LIST: begin
            if (out_free) begin
               cmd.rotate   = 1'b1;
               rsp_valid_in = 1'b1;
               status_in    = STAT_OK;
               element_in   = cell_data[0];
               final_in     = 1'b0;
               held_in      = count_ff;
               step_in      = step_ff + ONE_CNT;
               if (step_ff + ONE_CNT == count_ff) begin
                  state_in = S_CLOSE;
               end
            end
         end
         S_CLOSE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               status_in    = STAT_OK;
               element_in   = '0;
               final_in     = 1'b1;
               held_in      = count_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff  <= status_in;
      element_ff <= element_in;
      final_ff   <= final_in;
      held_ff    <= held_in;
   end

   for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic signed [DATA_W-1:0] right_data;
      if (gi == CAPACITY - 1) begin : g_last
         assign right_data = cell_data[gi];
      end else begin : g_mid
         assign right_data = cell_data[gi + 1];
      end
      olst_cell #(
         .IDX(gi)
      ) u_cell (
         .clock    (clock),
         .cmd      (cmd),
         .next_data(right_data),
         .head_data(cell_data[0]),
         .data     (cell_data[gi])
      );
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_element    = element_ff;
   assign rsp_is_final   = final_ff;
   assign rsp_held_count = held_ff;

   // count stays within the row
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_CNT)
      else $error("element count above capacity");

   // no request is taken while a listing runs
   a_list_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> req_stall)
      else $error("request taken during listing");

   // a non-closing transaction only comes out of a listing
   a_element_in_list: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !final_ff) |-> (state_ff == S_LIST || state_ff == S_CLOSE))
      else $error("element transaction outside listing");

   // an append that fits grows the list by one
   a_append_grows: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_kind == KIND_APPEND && count_ff < CAP_CNT)
      |=> (count_ff == $past(count_ff) + ONE_CNT))
      else $error("append did not grow the list");

endmodule

// ===== tb/ordered_list_store_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_store_core_tb
// Self-checking bench for the ordered list store. A shadow copy of the list
// predicts the responses of every accepted request. Each response is matched
// in order against the oldest prediction. Directed requests hit the empty and
// full edges and every operation. Random requests then swing the list between
// empty and full, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module ordered_list_store_core_tb;

   import olst_pkg::*;

   localparam int unsigned CAPACITY   = DEFAULT_CAPACITY;
   localparam int unsigned RAND_ITEMS = 350;
   localparam int unsigned LIMIT      = 1_200_000;
   localparam int unsigned SETTLE     = 40;

   // kind codes that the block treats as no-ops
   localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd5;
   localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

   localparam logic signed [DATA_W-1:0] VALUE_MIN = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;

   typedef struct {
      status_type               status;
      logic signed [DATA_W-1:0] element;
      logic                     is_final;
      logic [CNT_W-1:0]         held_count;
   } rsp_item_type;

   // shadow of the list contents plus the queue of predicted responses
   class list_shadow_type;
      logic signed [DATA_W-1:0] slot [CAPACITY];
      int unsigned held;
      rsp_item_type awaited [$];
      int unsigned errors;
      int unsigned checked;
      int unsigned list_passes;
      int unsigned full_hits;
      int unsigned empty_hits;
      int unsigned badpos_hits;

      function void push(status_type st, logic signed [DATA_W-1:0] el, logic fin);
         rsp_item_type r;
         r.status     = st;
         r.element    = el;
         r.is_final   = fin;
         r.held_count = held[CNT_W-1:0];
         awaited.push_back(r);
      endfunction

      function void take_request(logic [KIND_W-1:0] kind,
                                 logic signed [DATA_W-1:0] value,
                                 logic [CNT_W-1:0] pos);
         status_type st;
         st = STAT_OK;
         case (kind)
            KIND_APPEND: begin
               if (held >= CAPACITY) begin
                  st = STAT_FULL;
               end else begin
                  slot[held] = value;
                  held++;
               end
            end
            KIND_REMOVE_FIRST: begin
               if (held == 0) begin
                  st = STAT_EMPTY;
               end else begin
                  for (int i = 1; i < held; i++) slot[i-1] = slot[i];
                  held--;
               end
            end
            KIND_REMOVE_LAST: begin
               if (held == 0) st = STAT_EMPTY;
               else held--;
            end
            KIND_REMOVE_AT: begin
               if (held == 0) begin
                  st = STAT_EMPTY;
               end else if (pos == 0 || pos > held) begin
                  st = STAT_BADPOS;
               end else begin
                  for (int i = int'(pos); i < held; i++) slot[i-1] = slot[i];
                  held--;
               end
            end
            KIND_LIST_ALL: begin
               for (int i = 0; i < held; i++) push(STAT_OK, slot[i], 1'b0);
               list_passes++;
            end
            default: ;
         endcase
         if (st == STAT_FULL) full_hits++;
         if (st == STAT_EMPTY) empty_hits++;
         if (st == STAT_BADPOS) badpos_hits++;
         push(st, '0, 1'b1);
      endfunction

      function void match_response(logic [STAT_W-1:0] st, logic signed [DATA_W-1:0] el,
                                   logic fin, logic [CNT_W-1:0] cnt);
         rsp_item_type e;
         if (awaited.size() == 0) begin
            $display("%0t: unexpected transaction: status %0d element %0d final %0d count %0d",
                     $time, st, el, fin, cnt);
            errors++;
            return;
         end
         e = awaited.pop_front();
         checked++;
         if (st !== e.status) begin
            $display("%0t: status mismatch, expected %0d actual %0d", $time, e.status, st);
            errors++;
         end
         if (el !== e.element) begin
            $display("%0t: element mismatch, expected %0d actual %0d", $time, e.element, el);
            errors++;
         end
         if (fin !== e.is_final) begin
            $display("%0t: is_final mismatch, expected %0d actual %0d", $time, e.is_final, fin);
            errors++;
         end
         if (cnt !== e.held_count) begin
            $display("%0t: held_count mismatch, expected %0d actual %0d",
                     $time, e.held_count, cnt);
            errors++;
         end
      endfunction

      function int unsigned pending();
         return awaited.size();
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [KIND_W-1:0]        req_kind;
   logic signed [DATA_W-1:0] req_value;
   logic [CNT_W-1:0]         req_position;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic [STAT_W-1:0]        rsp_status;
   logic signed [DATA_W-1:0] rsp_element;
   logic                     rsp_is_final;
   logic [CNT_W-1:0]         rsp_held_count;

   list_shadow_type shadow = new();
   int unsigned cycle_count = 0;
   int unsigned sent = 0;

   ordered_list_store_core #(.CAPACITY(CAPACITY)) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_value      (req_value),
      .req_position   (req_position),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_element    (rsp_element),
      .rsp_is_final   (rsp_is_final),
      .rsp_held_count (rsp_held_count)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT) begin
         $display("%0t: timeout with %0d transactions outstanding", $time, shadow.pending());
         $display("CHECK FAILED");
         $finish;
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         shadow.match_response(rsp_status, rsp_element, rsp_is_final, rsp_held_count);
   end

   // mostly short gaps, a few long ones
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 15))
         0:       return VALUE_MIN;
         1:       return VALUE_MAX;
         2:       return '0;
         3:       return -1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [CNT_W-1:0] pick_position(int unsigned held);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70 && held > 0) return CNT_W'($urandom_range(1, held));
      if (r < 80) return '0;
      if (r < 90) return CNT_W'(held + 1);
      return CNT_W'($urandom_range(0, 63));
   endfunction

   // response side stall pattern: quiet stretches, random stalls, long holds
   initial begin
      int unsigned mode;
      int unsigned len;
      rsp_stall <= 1'b0;
      forever begin
         mode = $urandom_range(0, 9);
         len  = $urandom_range(10, 60);
         if (mode < 3) begin
            repeat (len) begin
               @(posedge clock);
               rsp_stall <= 1'b0;
            end
         end else if (mode < 8) begin
            repeat (len) begin
               @(posedge clock);
               rsp_stall <= ($urandom_range(0, 99) < 35);
            end
         end else begin
            @(posedge clock);
            rsp_stall <= 1'b1;
            repeat ($urandom_range(10, 30)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // one request transaction, then an optional idle gap
   task automatic send_request(input logic [KIND_W-1:0] kind,
                               input logic signed [DATA_W-1:0] value,
                               input logic [CNT_W-1:0] pos,
                               input int unsigned gap);
      req_valid    <= 1'b1;
      req_kind     <= kind;
      req_value    <= value;
      req_position <= pos;
      do @(posedge clock); while (req_stall);
      shadow.take_request(kind, value, pos);
      sent++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (shadow.pending() != 0);
   endtask

   initial begin
      logic [KIND_W-1:0] kind;
      int unsigned       r;
      int unsigned       gap;
      bit                fill_phase;

      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_kind     <= KIND_APPEND;
      req_value    <= '0;
      req_position <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty list corner cases
      send_request(KIND_LIST_ALL, '0, '0, pick_gap());
      send_request(KIND_REMOVE_FIRST, '0, '0, pick_gap());
      send_request(KIND_REMOVE_LAST, '0, '0, pick_gap());
      send_request(KIND_REMOVE_AT, '0, '0, pick_gap());

      // fill to capacity with the value extremes first
      send_request(KIND_APPEND, VALUE_MIN, '0, pick_gap());
      send_request(KIND_APPEND, VALUE_MAX, '0, pick_gap());
      send_request(KIND_APPEND, '0, '1, pick_gap());
      send_request(KIND_APPEND, -1, '0, pick_gap());
      while (shadow.held < CAPACITY) send_request(KIND_APPEND, $urandom, '0, pick_gap());

      send_request(KIND_APPEND, 32'sh5A5A_A5A5, '0, pick_gap());
      send_request(KIND_LIST_ALL, '0, '0, pick_gap());
      send_request(KIND_REMOVE_AT, '0, '0, pick_gap());
      send_request(KIND_REMOVE_AT, '0, '1, pick_gap());
      send_request(KIND_REMOVE_AT, '0, CNT_W'(CAPACITY), pick_gap());
      send_request(KIND_REMOVE_AT, '0, 6'd1, pick_gap());
      send_request(KIND_REMOVE_FIRST, '0, '0, pick_gap());
      send_request(KIND_REMOVE_LAST, '0, '0, pick_gap());
      send_request(KIND_SPARE_LO, '1, '1, pick_gap());
      send_request(KIND_SPARE_HI, '0, '0, pick_gap());
      wait_drained();

      for (int n = 0; n < RAND_ITEMS; n++) begin
         // alternate phases that grow and shrink the list
         fill_phase = ((n / 50) % 2) == 0;
         r = $urandom_range(0, 99);
         if (fill_phase) begin
            if (r < 62)      kind = KIND_APPEND;
            else if (r < 70) kind = KIND_REMOVE_FIRST;
            else if (r < 76) kind = KIND_REMOVE_LAST;
            else if (r < 86) kind = KIND_REMOVE_AT;
            else if (r < 96) kind = KIND_LIST_ALL;
            else             kind = KIND_W'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
         end else begin
            if (r < 15)      kind = KIND_APPEND;
            else if (r < 35) kind = KIND_REMOVE_FIRST;
            else if (r < 55) kind = KIND_REMOVE_LAST;
            else if (r < 82) kind = KIND_REMOVE_AT;
            else if (r < 96) kind = KIND_LIST_ALL;
            else             kind = KIND_W'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
         end
         gap = (n % 100 < 25) ? 0 : pick_gap();
         send_request(kind, pick_value(), pick_position(shadow.held), gap);
         if (n == RAND_ITEMS / 2) wait_drained();
      end

      wait_drained();
      repeat (SETTLE) @(posedge clock);

      $display("ran %0d requests and matched %0d responses over %0d list passes",
               sent, shadow.checked, shadow.list_passes);
      $display("status hits: full %0d, empty %0d, bad position %0d",
               shadow.full_hits, shadow.empty_hits, shadow.badpos_hits);
      if (shadow.errors == 0 && shadow.pending() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
